// ----- hw/rtl/tpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold peak tagger package
// Widths, types and codes shared by the peak tagger modules.
// ----------------------------------------------------------------------------
package tpt_pkg;

   localparam int WINDOW_DEPTH   = 64;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int COUNT_WIDTH    = 48;
   localparam int AGE_WIDTH      = $clog2(WINDOW_DEPTH);
   localparam int FILL_WIDTH     = $clog2(WINDOW_DEPTH + 1);
   localparam int LA_WIDTH       = 6;
   localparam int CSR_WIDTH      = 16;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int REQ_DATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * SAMPLE_WIDTH + COUNT_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [COUNT_WIDTH-1:0]         count_type;
   typedef logic [AGE_WIDTH-1:0]           age_type;
   typedef logic [FILL_WIDTH-1:0]          fill_type;

   typedef enum logic [1:0] {
      RING_HOLD,
      RING_LOAD,
      RING_DOWN,
      RING_UP
   } ring_op_type;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_THRESHOLD,
      CSR_SEARCH_SPAN,
      CSR_TAG_OFFSET,
      CSR_BLANK_LENGTH
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIX,
      ST_RESTORE,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/threshold_peak_tagger.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold peak tagger
// Passes samples through and tags the window maximum once the oldest sample
// of the look-ahead window crosses the threshold outside the blanking time.
//
//   Channel  Direction  Contents
//   req_     in         one sample per transaction
//   rsp_     out        sample, tag position and tag value; tuser is the tag flag
//   csr_     in         register writes, no read-back
//
// After a sample is accepted, the sample ring turns one cell per cycle: once
// to scan the window of span + 1 cells from cell 0, where span is the search
// span register, and once to turn it back; the tag is settled between the
// two turns and the result is loaded after them. The next sample is accepted
// only once that result is loaded.
// Reset is synchronous and clears control state and registers; the window
// cells are not cleared, as no detection reads a cell before it is filled.
// A result that is not taken holds the block before it returns to idle.
// ----------------------------------------------------------------------------
module threshold_peak_tagger (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [tpt_pkg::REQ_DATA_WIDTH-1:0]         req_tdata,  // sample_in
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // sample_out, tag_position, tag_value
   output logic [tpt_pkg::RSP_DATA_WIDTH-1:0]         rsp_tdata,
   output logic                                       rsp_tuser,  // tag_valid
   input  logic                                       csr_we,
   input  logic [tpt_pkg::CSR_ADDR_WIDTH-1:0]         csr_addr,
   input  logic [tpt_pkg::CSR_WIDTH-1:0]              csr_wdata
);
   import tpt_pkg::*;

   state_type             state_ff, state_in;
   count_type             count_ff, count_in;
   count_type             blank_until_ff, blank_until_in;
   fill_type              fill_ff, fill_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            threshold_ff, threshold_in;
   logic [LA_WIDTH-1:0]   search_span_ff, search_span_in;
   logic signed [15:0]    tag_offset_ff, tag_offset_in;
   logic [15:0]           blank_length_ff, blank_length_in;

   count_type             oldest_ff, oldest_in;
   count_type             base_ff, base_in;
   count_type             pos_ff, pos_in;
   sample_type            sample_ff, sample_in;
   sample_type            best_val_ff, best_val_in;
   age_type               best_age_ff, best_age_in;
   age_type               step_ff, step_in;
   logic                  thr_ok_ff, thr_ok_in;
   logic                  hit_ff, hit_in;
   sample_type            rsp_sample_ff, rsp_sample_in;
   logic                  rsp_tag_ff, rsp_tag_in;
   count_type             rsp_pos_ff, rsp_pos_in;
   sample_type            rsp_value_ff, rsp_value_in;

   ring_op_type           ring_op;
   sample_type            tap;
   age_type               la_eff;
   count_type             offset_ext;

   tpt_chain u_chain (
      .clock       (clock),
      .op          (ring_op),
      .load_sample (sample_type'(req_tdata[SAMPLE_WIDTH-1:0])),
      .tap         (tap)
   );

   assign la_eff = (int'(search_span_ff) > WINDOW_DEPTH - 1) ?
                   AGE_WIDTH'(WINDOW_DEPTH - 1) : AGE_WIDTH'(search_span_ff);
   assign offset_ext = {{(COUNT_WIDTH - 16){tag_offset_ff[15]}}, tag_offset_ff};

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      blank_until_in  = blank_until_ff;
      fill_in         = fill_ff;
      rsp_valid_in    = rsp_valid_ff;
      threshold_in    = threshold_ff;
      search_span_in  = search_span_ff;
      tag_offset_in   = tag_offset_ff;
      blank_length_in = blank_length_ff;
      oldest_in       = oldest_ff;
      base_in         = base_ff;
      pos_in          = pos_ff;
      sample_in       = sample_ff;
      best_val_in     = best_val_ff;
      best_age_in     = best_age_ff;
      step_in         = step_ff;
      thr_ok_in       = thr_ok_ff;
      hit_in          = hit_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_tag_in      = rsp_tag_ff;
      rsp_pos_in      = rsp_pos_ff;
      rsp_value_in    = rsp_value_ff;
      ring_op         = RING_HOLD;

      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_THRESHOLD:    threshold_in    = sample_type'(csr_wdata);
            CSR_SEARCH_SPAN:  search_span_in  = csr_wdata[LA_WIDTH-1:0];
            CSR_TAG_OFFSET:   tag_offset_in   = csr_wdata;
            CSR_BLANK_LENGTH: blank_length_in = csr_wdata;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ring_op   = RING_LOAD;
               sample_in = sample_type'(req_tdata[SAMPLE_WIDTH-1:0]);
               count_in  = count_ff + COUNT_WIDTH'(1);
               oldest_in = count_ff - COUNT_WIDTH'(la_eff);
               base_in   = count_ff + offset_ext;
               if (fill_ff != FILL_WIDTH'(WINDOW_DEPTH)) begin
                  fill_in = fill_ff + FILL_WIDTH'(1);
               end
               step_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ring_op = RING_DOWN;
            if (step_ff == '0 || tap >= best_val_ff) begin
               best_val_in = tap;
               best_age_in = step_ff;
            end
            if (step_ff == la_eff) begin
               thr_ok_in = tap > threshold_ff;
               step_in   = '0;
               state_in  = ST_FIX;
            end else begin
               step_in = step_ff + AGE_WIDTH'(1);
            end
         end
         ST_FIX: begin
            pos_in   = base_ff - COUNT_WIDTH'(best_age_ff);
            hit_in   = (fill_ff > FILL_WIDTH'(la_eff)) && (oldest_ff >= blank_until_ff)
                       && thr_ok_ff;
            state_in = ST_RESTORE;
         end
         ST_RESTORE: begin
            ring_op = RING_UP;
            if (step_ff == '0 && hit_ff) begin
               blank_until_in = pos_ff + COUNT_WIDTH'(blank_length_ff) + COUNT_WIDTH'(1);
            end
            if (step_ff == la_eff) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + AGE_WIDTH'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_ff;
               rsp_tag_in    = hit_ff;
               rsp_pos_in    = hit_ff ? pos_ff : '0;
               rsp_value_in  = hit_ff ? best_val_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         blank_until_ff  <= '0;
         fill_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         threshold_ff    <= '0;
         search_span_ff  <= '0;
         tag_offset_ff   <= '0;
         blank_length_ff <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         blank_until_ff  <= blank_until_in;
         fill_ff         <= fill_in;
         rsp_valid_ff    <= rsp_valid_in;
         threshold_ff    <= threshold_in;
         search_span_ff  <= search_span_in;
         tag_offset_ff   <= tag_offset_in;
         blank_length_ff <= blank_length_in;
      end
   end

   always_ff @(posedge clock) begin
      oldest_ff     <= oldest_in;
      base_ff       <= base_in;
      pos_ff        <= pos_in;
      sample_ff     <= sample_in;
      best_val_ff   <= best_val_in;
      best_age_ff   <= best_age_in;
      step_ff       <= step_in;
      thr_ok_ff     <= thr_ok_in;
      hit_ff        <= hit_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_tag_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({rsp_value_ff, rsp_pos_ff, rsp_sample_ff});

endmodule

// ----- hw/rtl/tpt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak tagger window cell
// Holds one sample of the window and moves it to either neighbour.
// ----------------------------------------------------------------------------
module tpt_cell (
   input  logic                 clock,
   input  tpt_pkg::ring_op_type op,
   input  tpt_pkg::sample_type  from_lo,
   input  tpt_pkg::sample_type  from_hi,
   output tpt_pkg::sample_type  value
);
   import tpt_pkg::*;

   sample_type value_ff;
   sample_type value_in;

   always_comb begin
      unique case (op)
         RING_HOLD:          value_in = value_ff;
         RING_LOAD, RING_UP: value_in = from_lo;
         RING_DOWN:          value_in = from_hi;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- hw/rtl/tpt_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak tagger sample ring
// A row of window cells closed into a ring; cell 0 holds the newest sample
// when the ring is at rest and is the single read tap.
// ----------------------------------------------------------------------------
module tpt_chain (
   input  logic                 clock,
   input  tpt_pkg::ring_op_type op,
   input  tpt_pkg::sample_type  load_sample,
   output tpt_pkg::sample_type  tap
);
   import tpt_pkg::*;

   sample_type cell_value [WINDOW_DEPTH];

   genvar i;
   generate
      for (i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
         sample_type lo;
         if (i == 0) begin : g_head
            assign lo = (op == RING_LOAD) ? load_sample : cell_value[WINDOW_DEPTH-1];
         end else begin : g_body
            assign lo = cell_value[i-1];
         end
         tpt_cell u_cell (
            .clock   (clock),
            .op      (op),
            .from_lo (lo),
            .from_hi (cell_value[(i + 1) % WINDOW_DEPTH]),
            .value   (cell_value[i])
         );
      end
   endgenerate

   assign tap = cell_value[0];

endmodule

// ----- hw/rtl/tpt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold peak tagger checker
// Port-level checks on the sample and result channels, bound to the top.
// ----------------------------------------------------------------------------
module tpt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [tpt_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [tpt_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                               rsp_tuser
);
   import tpt_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff + 2'(req_acc) - 2'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A result is never shown for a sample that has not been taken.
   a_no_result_without_sample: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || pend_ff != 2'd0) && (pend_ff != 2'd3))
      else $error("result transaction without a matching sample transaction");

   // One sample is worked on at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("sample accepted while the previous one is still in work");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown straight after reset");

   a_untagged_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[RSP_FIELD_BITS-1:SAMPLE_WIDTH] == '0)
      else $error("untagged result carries a position or a value");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result transaction changed");

   logic unused_req_data;
   assign unused_req_data = ^req_tdata;

endmodule

bind threshold_peak_tagger tpt_checker u_tpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- dv/peak_tag_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak tag result check
// Watches the sample, result and register channels of the threshold peak
// tagger. It keeps its own window of samples, sample counter and blanking
// limit, works out the result of every accepted sample and compares each
// result transaction with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module peak_tag_check
   import tpt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      rsp_tuser,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_WIDTH-1:0]      csr_wdata,
   output int                        fail_count,
   output int                        backlog
);

   localparam int POS_LSB  = SAMPLE_WIDTH;
   localparam int PEAK_LSB = SAMPLE_WIDTH + COUNT_WIDTH;

   typedef struct packed {
      sample_type sample;
      logic       hit;
      count_type  position;
      sample_type peak;
   } tag_outcome_type;

   tag_outcome_type pending_tags [$];

   sample_type             ring [WINDOW_DEPTH];
   int                     head;
   int                     fill;
   count_type              sample_total;
   count_type              blank_until;
   sample_type             thr_reg;
   logic [LA_WIDTH-1:0]    la_reg;
   sample_type             off_reg;
   logic [CSR_WIDTH-1:0]   blank_reg;

   function automatic tag_outcome_type track_sample(input sample_type s);
      tag_outcome_type r;
      count_type    newest;
      count_type    oldest;
      int           span;
      int           oslot;
      int           peak_at;
      sample_type   peak;
      newest = sample_total;
      span = int'(la_reg);
      head = (head + 1) % WINDOW_DEPTH;
      ring[head] = s;
      if (fill < WINDOW_DEPTH) begin
         fill++;
      end
      sample_total = sample_total + 1'b1;
      r = '0;
      r.sample = s;
      if (fill >= span + 1) begin
         oldest = newest - count_type'(span);
         oslot = (head + WINDOW_DEPTH - span) % WINDOW_DEPTH;
         if (oldest >= blank_until && ring[oslot] > thr_reg) begin
            peak = ring[oslot];
            peak_at = 0;
            for (int m = 1; m <= span; m++) begin
               if (ring[(oslot + m) % WINDOW_DEPTH] > peak) begin
                  peak = ring[(oslot + m) % WINDOW_DEPTH];
                  peak_at = m;
               end
            end
            r.hit = 1'b1;
            r.peak = peak;
            r.position = oldest + count_type'(peak_at)
                         + {{(COUNT_WIDTH-SAMPLE_WIDTH){off_reg[SAMPLE_WIDTH-1]}}, off_reg};
            blank_until = r.position + count_type'(blank_reg) + 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      tag_outcome_type want;
      tag_outcome_type got;
      if (reset) begin
         foreach (ring[i]) ring[i] = '0;
         head = WINDOW_DEPTH - 1;
         fill = 0;
         sample_total = '0;
         blank_until = '0;
         thr_reg = '0;
         la_reg = '0;
         off_reg = '0;
         blank_reg = '0;
         pending_tags.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.sample = rsp_tdata[SAMPLE_WIDTH-1:0];
            got.position = rsp_tdata[PEAK_LSB-1:POS_LSB];
            got.peak = rsp_tdata[PEAK_LSB+SAMPLE_WIDTH-1:PEAK_LSB];
            got.hit = rsp_tuser;
            if (pending_tags.size() == 0) begin
               $error("Result transaction arrived with no sample outstanding.");
               fail_count++;
            end else begin
               want = pending_tags.pop_front();
               if (got.sample !== want.sample) begin
                  $error("sample_out: expected %0d, got %0d", want.sample, got.sample);
                  fail_count++;
               end
               if (got.hit !== want.hit) begin
                  $error("tag_valid: expected %0d, got %0d", want.hit, got.hit);
                  fail_count++;
               end
               if (got.position !== want.position) begin
                  $error("tag_position: expected %0d, got %0d", want.position, got.position);
                  fail_count++;
               end
               if (got.peak !== want.peak) begin
                  $error("tag_value: expected %0d, got %0d", want.peak, got.peak);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_tags.push_back(track_sample(sample_type'(req_tdata[SAMPLE_WIDTH-1:0])));
         end
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_THRESHOLD: begin
                  thr_reg = csr_wdata[SAMPLE_WIDTH-1:0];
               end
               CSR_SEARCH_SPAN: begin
                  la_reg = csr_wdata[LA_WIDTH-1:0];
               end
               CSR_TAG_OFFSET: begin
                  off_reg = csr_wdata[SAMPLE_WIDTH-1:0];
               end
               CSR_BLANK_LENGTH: begin
                  blank_reg = csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
      backlog = pending_tags.size();
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold peak tagger testbench
// Drives samples into the tagger under random idling on both channels and
// reprograms its registers between phases: a short directed opening, random
// pulse-shaped phases, and two closing phases with the extreme tag offsets
// and blanking length. Results are checked by a separate module.
// ----------------------------------------------------------------------------
module tb_top;
   import tpt_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int ITEM_BUDGET = 1550;
   localparam int TAIL_ITEMS  = 60;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [CSR_WIDTH-1:0]      csr_wdata = '0;

   int         fail_count;
   int         backlog;
   int         cycles = 0;
   int         sent = 0;
   int         cur_thr = 0;
   int         burst_left = 0;
   sample_type last_sample = '0;
   logic       calm = 1'b0;

   threshold_peak_tagger uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   peak_tag_check scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 7);
   end

   task automatic send_sample(input sample_type value);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_WIDTH'(value);
      do @(posedge clock); while (!req_tready);
      sent++;
      calm = (sent >= 500 && sent < 800);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (backlog != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value[CSR_WIDTH-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input int thr, input int la, input int off, input int bl);
      drain();
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_SEARCH_SPAN, la);
      write_reg(CSR_TAG_OFFSET, off);
      write_reg(CSR_BLANK_LENGTH, bl);
      cur_thr = thr;
   endtask

   // Mostly quiet stretches at or below the threshold broken by short bursts above
   // it, with repeated values for ties and some fully random samples.
   function automatic sample_type make_sample();
      int roll;
      int r;
      int v;
      roll = $urandom_range(0, 99);
      r = $urandom_range(0, 3000);
      if (roll < 20) begin
         v = $urandom_range(0, 65535);
         v = v - 32768;
      end else if (roll < 30) begin
         v = last_sample;
      end else if (burst_left > 0) begin
         burst_left--;
         v = cur_thr + 1 + r;
      end else begin
         if (roll < 40) begin
            burst_left = $urandom_range(1, 8);
         end
         v = cur_thr - r;
      end
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      last_sample = sample_type'(v);
      return last_sample;
   endfunction

   initial begin
      int opening [8] = '{-32768, 32767, 0, -1, 1, 100, 100, 21845};
      int ties [10]   = '{150, 300, 300, 20, 101, 100, 500, 500, 0, -21846};
      int thr;
      int la;
      int off;
      int bl;
      int len;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      configure(-32768, 4, 0, 0);
      foreach (opening[i]) send_sample(sample_type'(opening[i]));
      configure(32767, 0, 0, 0);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      configure(100, 3, 2, 3);
      foreach (ties[i]) send_sample(sample_type'(ties[i]));
      configure(0, 0, -5, 0);
      repeat (5) send_sample(sample_type'($urandom_range(1, 32767)));

      while (sent < ITEM_BUDGET - TAIL_ITEMS) begin
         case ($urandom_range(0, 19))
            0: thr = -32768;
            1: thr = 32767;
            default: thr = int'($urandom_range(0, 12000)) - 4000;
         endcase
         case ($urandom_range(0, 9))
            0: la = 0;
            1: la = 63;
            2, 3: la = $urandom_range(0, 63);
            default: la = $urandom_range(1, 8);
         endcase
         off = (sent < 200) ? int'($urandom_range(0, 20)) : int'($urandom_range(0, 40)) - 20;
         case ($urandom_range(0, 19))
            0, 1: bl = 0;
            2: bl = $urandom_range(0, 400);
            default: bl = $urandom_range(0, 40);
         endcase
         len = (la > 16) ? $urandom_range(10, 25) : $urandom_range(20, 80);
         configure(thr, la, off, bl);
         repeat (len) send_sample(make_sample());
      end

      // The wrapped tag position blocks any later detection, so these come last.
      configure(-32768, 12, -32768, 65535);
      repeat (40) send_sample(make_sample());
      configure(-32768, 63, 32767, 0);
      repeat (20) send_sample(make_sample());

      drain();
      repeat (2 * WINDOW_DEPTH + 10) @(negedge clock);
      if (fail_count == 0 && backlog == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/tpt_pkg.sv
hw/rtl/tpt_cell.sv
hw/rtl/tpt_chain.sv
hw/rtl/threshold_peak_tagger.sv
hw/rtl/tpt_checker.sv
dv/peak_tag_check.sv
dv/tb_top.sv
